[rtl/cft_pkg.sv]
// ----------------------------------------------------------------------------
// Cumulative frequency table package
// Shared sizes, action codes and beat types of the frequency table.
// ----------------------------------------------------------------------------
package cft_pkg;

	localparam int ALPHABET_SIZE = 256;
	localparam int COUNT_BITS    = 32;

	localparam int SYM_W  = 8;
	localparam int RES_W  = 32;
	localparam int IDX_W  = $clog2(ALPHABET_SIZE);
	localparam int CNT_W  = COUNT_BITS;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_COUNT  = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;

	typedef struct packed {
		logic [1:0]       action;
		logic [SYM_W-1:0] symbol;
	} cft_in_t;

	typedef struct packed {
		logic             present;
		logic [RES_W-1:0] frequency;
		logic [RES_W-1:0] low_bound;
		logic [RES_W-1:0] high_bound;
	} cft_out_t;

	typedef struct packed {
		logic             wr_en;
		logic             clr;
		logic [IDX_W-1:0] addr;
		logic [CNT_W-1:0] wdata;
	} cft_store_req_t;

endpackage

[rtl/cft_store.sv]
// ----------------------------------------------------------------------------
// Count store
// One count per symbol in a single-port memory with registered read; per-entry
// valid bits make unwritten or cleared entries read as zero.
// ----------------------------------------------------------------------------
module cft_store (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cft_pkg::cft_store_req_t req,
	output logic [cft_pkg::CNT_W-1:0] rd_data
);
	import cft_pkg::*;

	logic [CNT_W-1:0]         mem [ALPHABET_SIZE];
	logic [ALPHABET_SIZE-1:0] valid_q;
	logic [CNT_W-1:0]         rd_q;
	logic                     rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= valid_q[req.addr];
			if (req.clr) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wdata;
		end
		rd_q <= mem[req.addr];
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

[rtl/cft_engine.sv]
// ----------------------------------------------------------------------------
// Table sequencer
// Walks the count store through one shared adder: increments a count, or sums
// the counts below a symbol and forms the high bound of a lookup.
// ----------------------------------------------------------------------------
module cft_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  cft_pkg::cft_in_t           item,
	input  logic [cft_pkg::CNT_W-1:0]  rd_data,
	output cft_pkg::cft_store_req_t    req,
	output logic                       busy,
	output logic                       res_load,
	output cft_pkg::cft_out_t          res,
	output logic [cft_pkg::CNT_W-1:0]  total
);
	import cft_pkg::*;

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_CNT_WR  = 2'd1;
	localparam logic [1:0] ST_LK_RUN  = 2'd2;
	localparam logic [1:0] ST_LK_WAIT = 2'd3;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	logic [1:0]       state_q;
	logic [IDX_W-1:0] sym_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] below_q;
	logic [CNT_W-1:0] total_q;
	logic             pend_q;

	logic             in_alpha;
	logic [IDX_W-1:0] sym_idx;
	logic [CNT_W-1:0] add_a;
	logic [CNT_W-1:0] sum;
	logic             accept;

	assign in_alpha = (9'(item.symbol) < 9'(ALPHABET_SIZE));
	assign sym_idx  = item.symbol[IDX_W-1:0];
	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign total    = total_q;

	// shared adder: increment in count write, accumulate or high bound in lookup
	assign add_a = (state_q == ST_CNT_WR) ? CNT_W'(1) : below_q;
	assign sum   = add_a + rd_data;

	always_comb begin
		req.wr_en = (state_q == ST_CNT_WR);
		req.clr   = accept && (item.action == ACT_CLEAR);
		req.wdata = sum;
		case (state_q)
			ST_IDLE:   req.addr = sym_idx;
			ST_LK_RUN: req.addr = idx_q;
			default:   req.addr = sym_q;
		endcase
	end

	always_comb begin
		res_load = 1'b0;
		res      = '0;
		if (state_q == ST_LK_WAIT) begin
			res_load       = 1'b1;
			res.present    = (rd_data != '0);
			res.frequency  = RES_W'(rd_data);
			res.low_bound  = RES_W'(below_q);
			res.high_bound = RES_W'(sum);
		end else if (accept && (item.action == ACT_LOOKUP) && !in_alpha) begin
			res_load       = 1'b1;
			res.low_bound  = RES_W'(total_q);
			res.high_bound = RES_W'(total_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			total_q <= '0;
			pend_q  <= 1'b0;
			sym_q   <= '0;
			idx_q   <= '0;
			below_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (item.action)
							ACT_CLEAR: total_q <= '0;
							ACT_COUNT: begin
								if (in_alpha && (total_q != CNT_MAX)) begin
									sym_q   <= sym_idx;
									state_q <= ST_CNT_WR;
								end
							end
							ACT_LOOKUP: begin
								if (in_alpha) begin
									sym_q   <= sym_idx;
									idx_q   <= '0;
									below_q <= '0;
									pend_q  <= 1'b0;
									state_q <= ST_LK_RUN;
								end
							end
							default: ;
						endcase
					end
				end
				ST_CNT_WR: begin
					total_q <= total_q + CNT_W'(1);
					state_q <= ST_IDLE;
				end
				ST_LK_RUN: begin
					// accumulate the entry read last cycle, issue the next one
					if (pend_q) begin
						below_q <= sum;
					end
					pend_q <= 1'b1;
					idx_q  <= idx_q + IDX_W'(1);
					if (idx_q == sym_q) begin
						state_q <= ST_LK_WAIT;
					end
				end
				ST_LK_WAIT: begin
					pend_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/cumulative_frequency_table.sv]
// ----------------------------------------------------------------------------
// Cumulative frequency table
// Per-symbol counts and running total for an arithmetic coder, with lookup of
// a symbol's count and its low and high cumulative bounds.
//
//   channel   handshake          payload
//   -------   ----------------   -------------------------------------
//   item      start, busy        action, symbol
//   result    done (1 cycle)     present, frequency, low_bound, high_bound
//
// Clear empties store and total; a count reads then writes the store. A
// lookup of symbol s walks entries 0..s through the single store read port
// and one adder; a symbol outside the alphabet answers without a walk.
// Reset empties the store at once through per-entry valid bits.
// done is a one-cycle strobe; results cannot be stalled.
// ----------------------------------------------------------------------------
module cumulative_frequency_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cft_pkg::cft_in_t  item,
	output logic              done,
	output cft_pkg::cft_out_t result
);
	import cft_pkg::*;

	cft_store_req_t   req;
	logic [CNT_W-1:0] rd_data;
	logic             res_load;
	cft_out_t         res;
	logic [CNT_W-1:0] total;
	logic             done_q;
	cft_out_t         result_q;

	cft_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	cft_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item),
		.rd_data  (rd_data),
		.req      (req),
		.busy     (busy),
		.res_load (res_load),
		.res      (res),
		.total    (total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			result_q <= res;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_bounds_sum: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.high_bound == result.low_bound + result.frequency))
		else $error("high bound differs from low bound plus frequency");

	a_present: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.present == (result.frequency != '0)))
		else $error("present flag disagrees with frequency");

	a_within_total: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.high_bound <= RES_W'(total)))
		else $error("high bound exceeds running total");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_en |-> busy)
		else $error("store written while idle");

endmodule
